@@ design/assert_macros.svh @@
// assertion helpers used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("esdscp assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("esdscp assertion failed");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ design/esdscp_pkg.sv @@
package esdscp_pkg;

  localparam logic [7:0] TAG_ES_CODE  = 8'h03;
  localparam logic [7:0] TAG_DC_CODE  = 8'h04;
  localparam logic [7:0] TAG_DSI_CODE = 8'h05;
  localparam logic [7:0] ESID_SKIP    = 8'd2;
  localparam logic [7:0] OPT_SKIP_LEN = 8'd2;
  localparam logic [7:0] DC_SKIP_LEN  = 8'd13;
  localparam logic [4:0] AOT_ESC      = 5'd31;
  localparam logic [3:0] SFI_ESC      = 4'hF;
  localparam logic [1:0] LEN_GROUPS_MAX = 2'd3;

  typedef enum logic [3:0] {
    PH_TAG_ES,
    PH_LEN_ES,
    PH_ESID,
    PH_FLAGS,
    PH_OPT_SKIP,
    PH_URL_LEN,
    PH_TAG_DC,
    PH_LEN_DC,
    PH_DC_SKIP,
    PH_TAG_DSI,
    PH_LEN_DSI,
    PH_ASC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [3:0] channel_config;
    logic [3:0] channel_count;
    logic       parse_status;
  } result_t;

  // channel config field and whether enough asc bytes have arrived to fix it
  typedef struct packed {
    logic [3:0] chan;
    logic       enough;
  } asc_field_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] skip;
    logic [2:0] flags;
  } flags_step_t;

  // optional es descriptor fields: dependency, url, ocr in that order
  function automatic flags_step_t after_flags(input logic [2:0] f);
    flags_step_t s;
    s.phase = PH_TAG_DC;
    s.skip  = '0;
    s.flags = '0;
    if (f[2]) begin
      s.flags = {1'b0, f[1:0]};
      s.skip  = OPT_SKIP_LEN;
      s.phase = PH_OPT_SKIP;
    end else if (f[1]) begin
      s.flags = {2'b00, f[0]};
      s.phase = PH_URL_LEN;
    end else if (f[0]) begin
      s.skip  = OPT_SKIP_LEN;
      s.phase = PH_OPT_SKIP;
    end
    return s;
  endfunction

  function automatic logic [3:0] channel_count_of(input logic [3:0] c);
    logic [3:0] n;
    case (c) inside
      [4'd1:4'd6]: n = c;
      4'd7:        n = 4'd8;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

@@ design/esds_channel_config_parser_core.sv @@
// latency: a result is registered at the edge that accepts the byte that settles it
// throughput: one byte per cycle while bytes are not held off; each byte needs one state update
// a spare result slot keeps bytes flowing while one result waits under stall;
// bytes are held off only while both result slots are full
// reset: synchronous, active high; parser returns to expecting the first tag
// the parser also returns to that state after every last byte
`include "assert_macros.svh"

module esds_channel_config_parser_core
  import esdscp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    item_valid,
  output logic    item_stall,
  output result_t result,
  output logic    result_valid,
  input  logic    result_stall
);

  phase_t      phase, phase_next;
  logic [7:0]  skip_left, skip_left_next;
  logic [27:0] length_value, length_value_next;
  logic [1:0]  length_groups, length_groups_next;
  logic [2:0]  stream_flags, stream_flags_next;
  logic [27:0] config_left, config_left_next;
  logic [47:0] asc, asc_next;
  logic [2:0]  asc_cnt, asc_cnt_next;
  result_t     spare;
  logic        spare_valid;

  logic        item_acc;
  logic        out_acc;
  logic        fire;
  logic        fresh_valid;
  result_t     fresh;
  logic        malformed;
  logic [3:0]  chan;
  logic [27:0] len_shift;
  logic        len_done;
  logic [47:0] asc_push;
  logic [2:0]  asc_cnt_inc;
  flags_step_t fstep;
  asc_field_t  field;

  assign item_stall  = spare_valid;
  assign item_acc    = item_valid && !item_stall;
  assign out_acc     = result_valid && !result_stall;
  assign fresh_valid = item_acc && fire;

  assign len_shift   = {length_value[20:0], item.data_byte[6:0]};
  assign len_done    = !item.data_byte[7] || (length_groups == LEN_GROUPS_MAX);
  assign asc_push    = asc | ({item.data_byte, 40'd0} >> {asc_cnt, 3'b000});
  assign asc_cnt_inc = asc_cnt + 3'd1;

  esdscp_asc_field u_field (
    .asc      (asc_push),
    .bytes_in (asc_cnt_inc),
    .field    (field)
  );

  always_comb begin
    phase_next         = phase;
    skip_left_next     = skip_left;
    length_value_next  = length_value;
    length_groups_next = length_groups;
    stream_flags_next  = stream_flags;
    config_left_next   = config_left;
    asc_next           = asc;
    asc_cnt_next       = asc_cnt;
    fire               = 1'b0;
    malformed          = 1'b0;
    chan               = 4'd0;
    fstep              = after_flags(stream_flags);

    if (item_acc) begin
      case (phase)
        PH_TAG_ES, PH_TAG_DC, PH_TAG_DSI: begin
          if ((phase == PH_TAG_ES && item.data_byte == TAG_ES_CODE) ||
              (phase == PH_TAG_DC && item.data_byte == TAG_DC_CODE) ||
              (phase == PH_TAG_DSI && item.data_byte == TAG_DSI_CODE)) begin
            length_value_next  = '0;
            length_groups_next = '0;
            phase_next = (phase == PH_TAG_ES) ? PH_LEN_ES :
                         (phase == PH_TAG_DC) ? PH_LEN_DC : PH_LEN_DSI;
          end else begin
            fire       = 1'b1;
            malformed  = 1'b1;
            phase_next = PH_DONE;
          end
        end
        PH_LEN_ES, PH_LEN_DC, PH_LEN_DSI: begin
          length_value_next  = len_shift;
          length_groups_next = len_done ? 2'd0 : length_groups + 2'd1;
          if (len_done) begin
            case (phase)
              PH_LEN_ES: begin
                skip_left_next = ESID_SKIP;
                phase_next     = PH_ESID;
              end
              PH_LEN_DC: begin
                skip_left_next = DC_SKIP_LEN;
                phase_next     = PH_DC_SKIP;
              end
              default: begin
                config_left_next = len_shift;
                asc_next         = '0;
                asc_cnt_next     = '0;
                phase_next       = PH_ASC;
              end
            endcase
          end
        end
        PH_ESID, PH_DC_SKIP: begin
          skip_left_next = skip_left - 8'd1;
          if (skip_left == 8'd1) begin
            phase_next = (phase == PH_ESID) ? PH_FLAGS : PH_TAG_DSI;
          end
        end
        PH_FLAGS: begin
          fstep             = after_flags(item.data_byte[7:5]);
          stream_flags_next = fstep.flags;
          skip_left_next    = fstep.skip;
          phase_next        = fstep.phase;
        end
        PH_OPT_SKIP: begin
          skip_left_next = skip_left - 8'd1;
          if (skip_left == 8'd1) begin
            stream_flags_next = fstep.flags;
            skip_left_next    = fstep.skip;
            phase_next        = fstep.phase;
          end
        end
        PH_URL_LEN: begin
          if (item.data_byte == 8'd0) begin
            stream_flags_next = fstep.flags;
            skip_left_next    = fstep.skip;
            phase_next        = fstep.phase;
          end else begin
            skip_left_next = item.data_byte;
            phase_next     = PH_OPT_SKIP;
          end
        end
        PH_ASC: begin
          asc_next     = asc_push;
          asc_cnt_next = asc_cnt_inc;
          chan         = field.chan;
          if (field.enough) begin
            fire       = 1'b1;
            phase_next = PH_DONE;
          end else if (config_left != 28'd0) begin
            config_left_next = config_left - 28'd1;
            // config length used up: the rest reads as zero bits
            if (config_left == 28'd1) begin
              fire       = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase

      // body ends without an answer yet
      if (item.last_byte && !fire && phase != PH_DONE) begin
        fire = 1'b1;
        if (phase == PH_ASC) begin
          chan = field.chan;
        end else begin
          malformed = 1'b1;
        end
      end

      if (item.last_byte) begin
        phase_next         = PH_TAG_ES;
        skip_left_next     = '0;
        length_value_next  = '0;
        length_groups_next = '0;
        stream_flags_next  = '0;
        config_left_next   = '0;
        asc_next           = '0;
        asc_cnt_next       = '0;
      end
    end
  end

  always_comb begin
    fresh.channel_config = malformed ? 4'd0 : chan;
    fresh.channel_count  = malformed ? 4'd0 : channel_count_of(chan);
    fresh.parse_status   = malformed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG_ES;
      skip_left     <= '0;
      length_value  <= '0;
      length_groups <= '0;
      stream_flags  <= '0;
      config_left   <= '0;
      asc           <= '0;
      asc_cnt       <= '0;
    end else begin
      phase         <= phase_next;
      skip_left     <= skip_left_next;
      length_value  <= length_value_next;
      length_groups <= length_groups_next;
      stream_flags  <= stream_flags_next;
      config_left   <= config_left_next;
      asc           <= asc_next;
      asc_cnt       <= asc_cnt_next;
    end
  end

  // a new result goes to the spare slot only while the output one is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else if (spare_valid) begin
      if (out_acc) begin
        spare_valid <= 1'b0;
      end
    end else if (fresh_valid) begin
      if (result_valid && result_stall) begin
        spare_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_acc) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (out_acc) begin
        result <= spare;
      end
    end else if (fresh_valid) begin
      if (result_valid && result_stall) begin
        spare <= fresh;
      end else begin
        result <= fresh;
      end
    end
  end

  `ASSERT_AT(a_last_resets, clk, rst, item_acc && item.last_byte |=> phase == PH_TAG_ES)
  `ASSERT_AT(a_result_from_item, clk, rst, $rose(result_valid) |-> $past(item_acc))
  `ASSERT_AT(a_malformed_zero, clk, rst, result_valid && result.parse_status |->
             result.channel_config == 4'd0 && result.channel_count == 4'd0)
  `ASSERT_NEVER(a_asc_cnt_range, clk, rst, asc_cnt > 3'd6)
  `ASSERT_AT(a_spare_behind_out, clk, rst, spare_valid |-> result_valid)

endmodule

@@ design/esdscp_asc_field.sv @@
module esdscp_asc_field
  import esdscp_pkg::*;
(
  input  logic [47:0] asc,
  input  logic [2:0]  bytes_in,
  output asc_field_t  field
);

  logic       type_esc;
  logic [3:0] freq;
  logic       freq_esc;
  logic [2:0] need;

  // asc holds the config bits msb-first, zeros past what has arrived
  always_comb begin
    type_esc = (asc[47:43] == AOT_ESC);
    freq     = type_esc ? asc[36:33] : asc[42:39];
    freq_esc = (freq == SFI_ESC);
    case ({type_esc, freq_esc})
      2'b00: begin
        field.chan = asc[38:35];
        need       = 3'd2;
      end
      2'b01: begin
        field.chan = asc[14:11];
        need       = 3'd5;
      end
      2'b10: begin
        field.chan = asc[32:29];
        need       = 3'd3;
      end
      default: begin
        field.chan = asc[8:5];
        need       = 3'd6;
      end
    endcase
    field.enough = (bytes_in >= need);
  end

endmodule
